// ===== hw/rtl/glyph_row_pixel_expander_top_macros.svh =====
// glyph_row_pixel_expander_top_macros.svh: assertion macros for the glyph row expander
// used by the port checker; no other dependencies
`ifndef GLYPH_ROW_PIXEL_EXPANDER_TOP_MACROS_SVH
`define GLYPH_ROW_PIXEL_EXPANDER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define GPE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// antecedent implies consequent in the next cycle, off during reset
`define GPE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// consequent holds in the cycle after reset
`define GPE_ASSERT_RST(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== hw/rtl/gpe_pkg.sv =====
// gpe_pkg.sv: widths, types, register codes and helpers of the glyph row expander
// no dependencies
package gpe_pkg;

  localparam int ROW_BITS       = 16;
  localparam int COORD_BITS     = 9;
  localparam int COLOR_BITS     = 8;
  localparam int WIDTH_BITS     = 5;
  localparam int HEIGHT_BITS    = 6;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 8;
  localparam int MAX_PIX        = 16;
  localparam int MAX_HEIGHT     = 32;
  localparam int WIDTH_TOP      = (ROW_BITS < MAX_PIX) ? ROW_BITS : MAX_PIX;

  localparam logic [WIDTH_BITS-1:0]  GLYPH_WIDTH_RESET  = WIDTH_BITS'(8);
  localparam logic [HEIGHT_BITS-1:0] GLYPH_HEIGHT_RESET = HEIGHT_BITS'(16);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
  } rgb_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]  glyph_width;
    logic [HEIGHT_BITS-1:0] glyph_height;
    rgb_t                   bg;
  } cfg_t;

  // one row handed from the character tracker to the serializer
  typedef struct packed {
    logic [ROW_BITS-1:0]   bits;
    coord_t                left;
    coord_t                line;
    rgb_t                  fg;
    logic                  last_row;
    logic [WIDTH_BITS-1:0] count;
  } row_ctx_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_GLYPH_WIDTH  = CFG_INDEX_BITS'(0),
    CFG_GLYPH_HEIGHT = CFG_INDEX_BITS'(1),
    CFG_BG_RED       = CFG_INDEX_BITS'(2),
    CFG_BG_GREEN     = CFG_INDEX_BITS'(3),
    CFG_BG_BLUE      = CFG_INDEX_BITS'(4)
  } cfg_reg_e;

  function automatic logic [WIDTH_BITS-1:0] eff_width(input logic [WIDTH_BITS-1:0] w);
    logic [WIDTH_BITS-1:0] r;
    if (w == '0) begin
      r = WIDTH_BITS'(1);
    end else if (int'(w) > WIDTH_TOP) begin
      r = WIDTH_BITS'(WIDTH_TOP);
    end else begin
      r = w;
    end
    return r;
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] eff_height(input logic [HEIGHT_BITS-1:0] h);
    logic [HEIGHT_BITS-1:0] r;
    if (h == '0) begin
      r = HEIGHT_BITS'(1);
    end else if (int'(h) > MAX_HEIGHT) begin
      r = HEIGHT_BITS'(MAX_HEIGHT);
    end else begin
      r = h;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/gpe_if.sv =====
// gpe_if.sv: valid/ready channels for glyph rows in and pixels out
// depends on gpe_pkg
interface gpe_in_if
  import gpe_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                start_char;
  logic                continue_string;
  coord_t              origin_h;
  coord_t              origin_v;
  color_t              fg_red;
  color_t              fg_green;
  color_t              fg_blue;
  logic [ROW_BITS-1:0] glyph_row;

  modport source (
    output valid, start_char, continue_string, origin_h, origin_v,
           fg_red, fg_green, fg_blue, glyph_row,
    input  ready
  );
  modport sink (
    input  valid, start_char, continue_string, origin_h, origin_v,
           fg_red, fg_green, fg_blue, glyph_row,
    output ready
  );
endinterface

interface gpe_pix_if
  import gpe_pkg::*;
;
  logic   valid;
  logic   ready;
  color_t pix_red;
  color_t pix_green;
  color_t pix_blue;
  coord_t pix_x;
  coord_t pix_y;
  logic   row_end;
  logic   char_end;

  modport source (
    output valid, pix_red, pix_green, pix_blue, pix_x, pix_y, row_end, char_end,
    input  ready
  );
  modport sink (
    input  valid, pix_red, pix_green, pix_blue, pix_x, pix_y, row_end, char_end,
    output ready
  );
endinterface

// ===== hw/rtl/glyph_row_pixel_expander_top.sv =====
// path: row stage register, serializer shift register, then pixel output register
// throughput: one pixel per cycle unless pix_out.ready stalls it, a row being effective
//   glyph_width (1 to 16) pixels; the next row is taken while the current one is still
//   being shifted out; the serializer shifting out one pixel per cycle sets that figure
// reset (rst, synchronous, active high): config back to width 8, height 16, black
//   background; character at column 0, line 0, row 0 with black foreground
module glyph_row_pixel_expander_top
  import gpe_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  gpe_in_if.sink                    row_in,
  gpe_pix_if.source                 pix_out
);

  // live configuration; to be changed only while no item is in flight, not enforced here
  cfg_t     cfg;

  // row handed from the tracker to the serializer
  row_ctx_t ctx;
  logic     ctx_valid;
  logic     ctx_ready;

  gpe_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // registers each row item, resolves origin, line and colour of the character
  gpe_row_stage u_row_stage (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .row_in    (row_in),
    .ctx       (ctx),
    .ctx_valid (ctx_valid),
    .ctx_ready (ctx_ready)
  );

  // emits the row msb first into the pixel output register
  gpe_pixel_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .bg        (cfg.bg),
    .ctx       (ctx),
    .ctx_valid (ctx_valid),
    .ctx_ready (ctx_ready),
    .pix_out   (pix_out)
  );

endmodule

// ===== hw/rtl/gpe_cfg_regs.sv =====
// gpe_cfg_regs.sv: configuration register file of the glyph row expander
// depends on gpe_pkg
module gpe_cfg_regs
  import gpe_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_width  <= GLYPH_WIDTH_RESET;
      cfg.glyph_height <= GLYPH_HEIGHT_RESET;
      cfg.bg           <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GLYPH_WIDTH:  cfg.glyph_width  <= cfg_data[WIDTH_BITS-1:0];
        CFG_GLYPH_HEIGHT: cfg.glyph_height <= cfg_data[HEIGHT_BITS-1:0];
        CFG_BG_RED:       cfg.bg.red       <= cfg_data[COLOR_BITS-1:0];
        CFG_BG_GREEN:     cfg.bg.green     <= cfg_data[COLOR_BITS-1:0];
        CFG_BG_BLUE:      cfg.bg.blue      <= cfg_data[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/gpe_row_stage.sv =====
// gpe_row_stage.sv: input register and character position tracking
// depends on gpe_pkg and gpe_if
module gpe_row_stage
  import gpe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  gpe_in_if.sink   row_in,
  output row_ctx_t ctx,
  output logic     ctx_valid,
  input  logic     ctx_ready
);

  coord_t                 char_left;
  coord_t                 line_now;
  logic [WIDTH_BITS-1:0]  row_index;
  rgb_t                   fg_colour;

  logic                   accept;
  logic [WIDTH_BITS-1:0]  w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  coord_t                 left_use;
  coord_t                 line_use;
  logic [WIDTH_BITS-1:0]  row_use;
  rgb_t                   fg_use;
  logic                   last_row;
  row_ctx_t               ctx_next;

  assign row_in.ready = !ctx_valid || ctx_ready;
  assign accept       = row_in.valid && row_in.ready;

  always_comb begin
    w_eff = eff_width(cfg.glyph_width);
    h_eff = eff_height(cfg.glyph_height);
    if (row_in.start_char) begin
      left_use = row_in.continue_string ? char_left + COORD_BITS'(w_eff) : row_in.origin_h;
      line_use = row_in.origin_v;
      row_use  = '0;
      fg_use   = '{red: row_in.fg_red, green: row_in.fg_green, blue: row_in.fg_blue};
    end else begin
      left_use = char_left;
      line_use = line_now;
      row_use  = row_index;
      fg_use   = fg_colour;
    end
    last_row = (HEIGHT_BITS'(row_use) + HEIGHT_BITS'(1)) >= h_eff;
    ctx_next = '{bits: row_in.glyph_row, left: left_use, line: line_use, fg: fg_use,
                 last_row: last_row, count: w_eff};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_left <= '0;
      line_now  <= '0;
      row_index <= '0;
      fg_colour <= '0;
      ctx_valid <= 1'b0;
    end else if (accept) begin
      char_left <= left_use;
      line_now  <= line_use + COORD_BITS'(1);
      row_index <= last_row ? '0 : row_use + WIDTH_BITS'(1);
      fg_colour <= fg_use;
      ctx_valid <= 1'b1;
    end else if (ctx_ready) begin
      ctx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctx <= ctx_next;
    end
  end

endmodule

// ===== hw/rtl/gpe_pixel_serializer.sv =====
// gpe_pixel_serializer.sv: shifts one glyph row out as one pixel per cycle unless pix_out.ready stalls it
// depends on gpe_pkg and gpe_if
module gpe_pixel_serializer
  import gpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  rgb_t       bg,
  input  row_ctx_t   ctx,
  input  logic       ctx_valid,
  output logic       ctx_ready,
  gpe_pix_if.source  pix_out
);

  logic                  busy;
  logic [ROW_BITS-1:0]   bits;
  coord_t                x;
  coord_t                y;
  rgb_t                  fg;
  logic                  last_row;
  logic [WIDTH_BITS-1:0] left_cnt;

  logic advance;
  logic final_pix;
  logic load;
  rgb_t colour;

  assign advance   = busy && (!pix_out.valid || pix_out.ready);
  assign final_pix = left_cnt == WIDTH_BITS'(1);
  assign ctx_ready = !busy || (advance && final_pix);
  assign load      = ctx_valid && ctx_ready;
  assign colour    = bits[ROW_BITS-1] ? fg : bg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      pix_out.valid <= 1'b0;
    end else begin
      if (advance) begin
        pix_out.valid <= 1'b1;
      end else if (pix_out.ready) begin
        pix_out.valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (advance && final_pix) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix_out.pix_red   <= colour.red;
      pix_out.pix_green <= colour.green;
      pix_out.pix_blue  <= colour.blue;
      pix_out.pix_x     <= x;
      pix_out.pix_y     <= y;
      pix_out.row_end   <= final_pix;
      pix_out.char_end  <= final_pix && last_row;
    end
    if (load) begin
      bits     <= ctx.bits;
      x        <= ctx.left;
      y        <= ctx.line;
      fg       <= ctx.fg;
      last_row <= ctx.last_row;
      left_cnt <= ctx.count;
    end else if (advance) begin
      bits     <= bits << 1;
      x        <= x + COORD_BITS'(1);
      left_cnt <= left_cnt - WIDTH_BITS'(1);
    end
  end

endmodule

// ===== hw/rtl/gpe_checker.sv =====
// gpe_checker.sv: port level checks of the glyph row expander, bound to the top level
// depends on gpe_pkg and glyph_row_pixel_expander_top_macros.svh
`include "glyph_row_pixel_expander_top_macros.svh"

module gpe_checker
  import gpe_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   pix_valid,
  input logic   pix_ready,
  input coord_t pix_x,
  input coord_t pix_y,
  input logic   row_end,
  input logic   char_end
);

  `GPE_ASSERT_NXT(a_pix_hold, clk, rst, pix_valid && !pix_ready, pix_valid)
  `GPE_ASSERT_IMP(a_char_end_on_row_end, clk, rst, pix_valid && char_end, row_end)
  `GPE_ASSERT_NXT(a_row_runs_on, clk, rst, pix_valid && pix_ready && !row_end, pix_valid && (pix_x == COORD_BITS'($past(pix_x) + COORD_BITS'(1))) && (pix_y == $past(pix_y)))
  `GPE_ASSERT_RST(a_reset_empty, clk, rst, !pix_valid)

endmodule

bind glyph_row_pixel_expander_top gpe_checker u_gpe_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix_out.valid),
  .pix_ready (pix_out.ready),
  .pix_x     (pix_out.pix_x),
  .pix_y     (pix_out.pix_y),
  .row_end   (pix_out.row_end),
  .char_end  (pix_out.char_end)
);
